### rtl/phase_shift_extrapolation_macros.svh
// Assertion helpers for the phase-shift extrapolation block
`ifndef PHASE_SHIFT_EXTRAPOLATION_MACROS_SVH
`define PHASE_SHIFT_EXTRAPOLATION_MACROS_SVH

// Implication checked at every clock edge, off while reset is asserted.
`define PSE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pse check failed");

// Next-cycle implication, off while reset is asserted.
`define PSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pse check failed");

`endif

### rtl/pse_pkg.sv
`default_nettype none
package pse_pkg;
    localparam int TABLE_LEN = 24;
    localparam logic [33:0] PI_Q30      = 34'h0C90FDAA2;
    localparam logic [33:0] HALF_PI_Q30 = 34'h06487ED51;
    localparam logic [33:0] TWO_PI_Q30  = 34'h1921FB544;
    localparam logic signed [33:0] INV_GAIN_Q30 = 34'sh026DD3B6A;
    // square root: 17 result bits, one per stage
    localparam int ROOT_BITS = 17;

    typedef logic signed [33:0] cq_t;

    function automatic logic [29:0] atan_q30(input int i);
        case (i)
            0: atan_q30 = 30'h3243F6A8;
            1: atan_q30 = 30'h1DAC6705;
            2: atan_q30 = 30'h0FADBAFD;
            3: atan_q30 = 30'h07F56EA6;
            4: atan_q30 = 30'h03FEAB76;
            5: atan_q30 = 30'h01FFD55B;
            6: atan_q30 = 30'h00FFFAAA;
            7: atan_q30 = 30'h007FFF55;
            8: atan_q30 = 30'h003FFFEA;
            9: atan_q30 = 30'h001FFFFD;
            10: atan_q30 = 30'h000FFFFF;
            11: atan_q30 = 30'h0007FFFF;
            12: atan_q30 = 30'h0003FFFF;
            13: atan_q30 = 30'h0001FFFF;
            14: atan_q30 = 30'h0000FFFF;
            15: atan_q30 = 30'h00007FFF;
            16: atan_q30 = 30'h00003FFF;
            17: atan_q30 = 30'h00001FFF;
            18: atan_q30 = 30'h00000FFF;
            19: atan_q30 = 30'h000007FF;
            20: atan_q30 = 30'h000003FF;
            21: atan_q30 = 30'h000001FF;
            22: atan_q30 = 30'h000000FF;
            23: atan_q30 = 30'h0000007F;
            default: atan_q30 = 30'h0;
        endcase
    endfunction
endpackage
`default_nettype wire

### rtl/pse_sqrt.sv
`default_nettype none
// Pipelined floor square root of the 33-bit kz^2, one result bit per stage.
module pse_sqrt #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [32:0]                   radicand,
    input  wire logic                          in_evan,
    input  wire logic signed [SAMPLE_BITS-1:0] in_a,
    input  wire logic signed [SAMPLE_BITS-1:0] in_b,
    output logic                               out_valid,
    output logic [pse_pkg::ROOT_BITS-1:0]      root,
    output logic                               out_evan,
    output logic signed [SAMPLE_BITS-1:0]      out_a,
    output logic signed [SAMPLE_BITS-1:0]      out_b
);
    import pse_pkg::*;
    localparam int N = ROOT_BITS;

    logic                          v_reg   [N+1];
    logic [33:0]                   rem_reg [N+1];
    logic [N-1:0]                  rt_reg  [N+1];
    logic                          e_reg   [N+1];
    logic signed [SAMPLE_BITS-1:0] a_reg   [N+1];
    logic signed [SAMPLE_BITS-1:0] b_reg   [N+1];

    always_comb begin
        v_reg[0]   = in_valid;
        rem_reg[0] = {1'b0, radicand};
        rt_reg[0]  = '0;
        e_reg[0]   = in_evan;
        a_reg[0]   = in_a;
        b_reg[0]   = in_b;
    end

    for (genvar g = 0; g < N; g++) begin : g_st
        localparam int SH = 2 * (N - 1 - g);
        logic [33:0]  trial;
        logic [33:0]  rem_next;
        logic [N-1:0] rt_next;
        always_comb begin
            // compare remainder against (4*root+1) aligned at this bit pair
            trial = ({17'd0, rt_reg[g]} << (SH + 2)) | (34'd1 << SH);
            if (rem_reg[g] >= trial) begin
                rem_next = rem_reg[g] - trial;
                rt_next  = {rt_reg[g][N-2:0], 1'b1};
            end else begin
                rem_next = rem_reg[g];
                rt_next  = {rt_reg[g][N-2:0], 1'b0};
            end
        end
        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) v_reg[g+1] <= 1'b0;
            else if (en) v_reg[g+1] <= v_reg[g];
        end
        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[g+1] <= rem_next;
                rt_reg[g+1]  <= rt_next;
                e_reg[g+1]   <= e_reg[g];
                a_reg[g+1]   <= a_reg[g];
                b_reg[g+1]   <= b_reg[g];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign root      = rt_reg[N];
    assign out_evan  = e_reg[N];
    assign out_a     = a_reg[N];
    assign out_b     = b_reg[N];
endmodule
`default_nettype wire

### rtl/pse_cordic.sv
`default_nettype none
// Rotation-mode CORDIC, one registered stage per iteration.
module pse_cordic #(
    parameter int SAMPLE_BITS   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire pse_pkg::cq_t                  angle,
    input  wire logic                          in_neg,
    input  wire logic                          in_evan,
    input  wire logic signed [SAMPLE_BITS-1:0] in_a,
    input  wire logic signed [SAMPLE_BITS-1:0] in_b,
    output logic                               out_valid,
    output pse_pkg::cq_t                       cos_q30,
    output pse_pkg::cq_t                       sin_q30,
    output logic                               out_evan,
    output logic signed [SAMPLE_BITS-1:0]      out_a,
    output logic signed [SAMPLE_BITS-1:0]      out_b
);
    import pse_pkg::*;
    localparam int N = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

    logic                          v_reg [N+1];
    cq_t                           x_reg [N+1];
    cq_t                           y_reg [N+1];
    cq_t                           z_reg [N+1];
    logic                          n_reg [N+1];
    logic                          e_reg [N+1];
    logic signed [SAMPLE_BITS-1:0] a_reg [N+1];
    logic signed [SAMPLE_BITS-1:0] b_reg [N+1];

    always_comb begin
        v_reg[0] = in_valid;
        x_reg[0] = INV_GAIN_Q30;
        y_reg[0] = '0;
        z_reg[0] = angle;
        n_reg[0] = in_neg;
        e_reg[0] = in_evan;
        a_reg[0] = in_a;
        b_reg[0] = in_b;
    end

    for (genvar g = 0; g < N; g++) begin : g_st
        cq_t dx, dy, at, x_next, y_next, z_next;
        always_comb begin
            dx = y_reg[g] >>> g;
            dy = x_reg[g] >>> g;
            at = cq_t'({4'd0, atan_q30(g)});
            if (!z_reg[g][33]) begin
                x_next = x_reg[g] - dx;
                y_next = y_reg[g] + dy;
                z_next = z_reg[g] - at;
            end else begin
                x_next = x_reg[g] + dx;
                y_next = y_reg[g] - dy;
                z_next = z_reg[g] + at;
            end
        end
        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) v_reg[g+1] <= 1'b0;
            else if (en) v_reg[g+1] <= v_reg[g];
        end
        always_ff @(posedge clk) begin
            if (en) begin
                x_reg[g+1] <= x_next;
                y_reg[g+1] <= y_next;
                z_reg[g+1] <= z_next;
                n_reg[g+1] <= n_reg[g];
                e_reg[g+1] <= e_reg[g];
                a_reg[g+1] <= a_reg[g];
                b_reg[g+1] <= b_reg[g];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign cos_q30   = n_reg[N] ? -x_reg[N] : x_reg[N];
    assign sin_q30   = n_reg[N] ? -y_reg[N] : y_reg[N];
    assign out_evan  = e_reg[N];
    assign out_a     = a_reg[N];
    assign out_b     = b_reg[N];
endmodule
`default_nettype wire

### rtl/phase_shift_extrapolation.sv
`default_nettype none
// channel   signals                                              handshake
// in        sample_re sample_im wavenumber freq_over_velocity    in_valid/in_ready
// out       shifted_re shifted_im evanescent                     out_valid/out_ready
// config    depth_step_data                                      depth_step_we
//
// Pipeline order: input stages, square root, phase wrap, CORDIC, output stages.
// One beat per cycle sustained while out is not stalled; the square root and CORDIC are fully pipelined.
// Reset clears all valid bits; depth_step resets to 1.0 m.
// A stall on out freezes the whole pipe; in_ready follows out_ready or an empty out stage.
module phase_shift_extrapolation #(
    parameter int SAMPLE_BITS   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_re,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_im,
    input  wire logic signed [15:0]            wavenumber,
    input  wire logic [15:0]                   freq_over_velocity,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0]      shifted_re,
    output logic signed [SAMPLE_BITS-1:0]      shifted_im,
    output logic                               evanescent,
    input  wire logic                          depth_step_we,
    input  wire logic [15:0]                   depth_step_data
);
    import pse_pkg::*;
    `include "phase_shift_extrapolation_macros.svh"

    localparam int PW = 2 * SAMPLE_BITS + 35;

    logic en;
    logic [15:0] depth_step_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) depth_step_reg <= 16'd256;
        else if (depth_step_we) depth_step_reg <= depth_step_data;
    end

    // stage 1: |k| and compare; stage 2: squares
    logic                          v1_reg, e1_reg;
    logic [16:0]                   fov1_reg, ak1_reg;
    logic signed [SAMPLE_BITS-1:0] a1_reg, b1_reg;
    logic [16:0] absk;
    assign absk = wavenumber[15] ? 17'(-{wavenumber[15], wavenumber})
                                 : {1'b0, wavenumber};
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) v1_reg <= 1'b0;
        else if (en) v1_reg <= in_valid;
    end
    always_ff @(posedge clk) begin
        if (en) begin
            fov1_reg <= {1'b0, freq_over_velocity};
            ak1_reg  <= absk;
            e1_reg   <= {1'b0, freq_over_velocity} < absk;
            a1_reg   <= sample_re;
            b1_reg   <= sample_im;
        end
    end

    logic v2_reg, e2_reg;
    logic [33:0] fsq2_reg, ksq2_reg;
    logic signed [SAMPLE_BITS-1:0] a2_reg, b2_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1_reg;
    end
    always_ff @(posedge clk) begin
        if (en) begin
            fsq2_reg <= fov1_reg * fov1_reg;
            ksq2_reg <= ak1_reg * ak1_reg;
            e2_reg   <= e1_reg;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
        end
    end

    logic v3_reg, e3_reg;
    logic [32:0] rad3_reg;
    logic signed [SAMPLE_BITS-1:0] a3_reg, b3_reg;
    logic [33:0] diff;
    assign diff = fsq2_reg - ksq2_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) v3_reg <= 1'b0;
        else if (en) v3_reg <= v2_reg;
    end
    always_ff @(posedge clk) begin
        if (en) begin
            rad3_reg <= e2_reg ? 33'd0 : diff[32:0];
            e3_reg   <= e2_reg;
            a3_reg   <= a2_reg;
            b3_reg   <= b2_reg;
        end
    end

    logic sq_v, sq_e;
    logic [ROOT_BITS-1:0] kz;
    logic signed [SAMPLE_BITS-1:0] sq_a, sq_b;
    pse_sqrt #(.SAMPLE_BITS(SAMPLE_BITS)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v3_reg), .radicand(rad3_reg),
        .in_evan(e3_reg), .in_a(a3_reg), .in_b(b3_reg), .out_valid(sq_v),
        .root(kz), .out_evan(sq_e), .out_a(sq_a), .out_b(sq_b)
    );

    // phase = kz*dz << 10 (< 2^43); reduce mod 2pi: quotient below 2^10
    logic v4_reg, e4_reg;
    logic [32:0] ph4_reg;
    logic signed [SAMPLE_BITS-1:0] a4_reg, b4_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) v4_reg <= 1'b0;
        else if (en) v4_reg <= sq_v;
    end
    always_ff @(posedge clk) begin
        if (en) begin
            ph4_reg <= kz * depth_step_reg;
            e4_reg  <= sq_e;
            a4_reg  <= sq_a;
            b4_reg  <= sq_b;
        end
    end

    // quotient estimate by reciprocal: floor(2^62/(2pi in Q.30)) ~ 683565275
    logic [42:0] phase4;
    logic [63:0] qprod;
    logic [10:0] qest;
    assign phase4 = {ph4_reg, 10'd0};
    assign qprod  = {31'd0, ph4_reg} * 64'd683565275;
    assign qest   = qprod[62:52];

    logic v5_reg, e5_reg;
    logic [42:0] ph5_reg;
    logic [10:0] q5_reg;
    logic signed [SAMPLE_BITS-1:0] a5_reg, b5_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) v5_reg <= 1'b0;
        else if (en) v5_reg <= v4_reg;
    end
    always_ff @(posedge clk) begin
        if (en) begin
            ph5_reg <= phase4;
            q5_reg  <= qest;
            e5_reg  <= e4_reg;
            a5_reg  <= a4_reg;
            b5_reg  <= b4_reg;
        end
    end

    // remainder estimate; underestimated quotient leaves r < 3*2pi
    logic [42:0] r5;
    logic [34:0] r5a, r5b, rem5;
    assign r5   = ph5_reg - 43'(q5_reg * {9'd0, TWO_PI_Q30});
    assign r5a  = (r5[34:0] >= {1'b0, TWO_PI_Q30}) ? r5[34:0] - {1'b0, TWO_PI_Q30} : r5[34:0];
    assign r5b  = (r5a >= {1'b0, TWO_PI_Q30}) ? r5a - {1'b0, TWO_PI_Q30} : r5a;
    assign rem5 = r5b;

    logic vr_reg, er_reg;
    logic [34:0] remr_reg;
    logic signed [SAMPLE_BITS-1:0] ar_reg, br_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) vr_reg <= 1'b0;
        else if (en) vr_reg <= v5_reg;
    end
    always_ff @(posedge clk) begin
        if (en) begin
            remr_reg <= rem5;
            er_reg   <= e5_reg;
            ar_reg   <= a5_reg;
            br_reg   <= b5_reg;
        end
    end

    logic v6_reg, e6_reg, n6_reg;
    cq_t z6_reg;
    logic signed [SAMPLE_BITS-1:0] a6_reg, b6_reg;
    cq_t zw, zf;
    logic negf;
    always_comb begin
        zw = (remr_reg > {1'b0, PI_Q30}) ? cq_t'(remr_reg - {1'b0, TWO_PI_Q30})
                                         : cq_t'(remr_reg);
        negf = 1'b0;
        zf = zw;
        if (zw > cq_t'(HALF_PI_Q30)) begin
            zf = zw - cq_t'(PI_Q30);
            negf = 1'b1;
        end else if (zw < -cq_t'(HALF_PI_Q30)) begin
            zf = zw + cq_t'(PI_Q30);
            negf = 1'b1;
        end
    end
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) v6_reg <= 1'b0;
        else if (en) v6_reg <= vr_reg;
    end
    always_ff @(posedge clk) begin
        if (en) begin
            z6_reg <= zf;
            n6_reg <= negf;
            e6_reg <= er_reg;
            a6_reg <= ar_reg;
            b6_reg <= br_reg;
        end
    end

    logic cv, ce;
    cq_t cc, cs;
    logic signed [SAMPLE_BITS-1:0] ca, cb;
    pse_cordic #(.SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v6_reg), .angle(z6_reg),
        .in_neg(n6_reg), .in_evan(e6_reg), .in_a(a6_reg), .in_b(b6_reg),
        .out_valid(cv), .cos_q30(cc), .sin_q30(cs), .out_evan(ce),
        .out_a(ca), .out_b(cb)
    );

    // four partial products, registered
    logic v7_reg, e7_reg;
    logic signed [PW-1:0] ac7_reg, bs7_reg, as7_reg, bc7_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) v7_reg <= 1'b0;
        else if (en) v7_reg <= cv;
    end
    always_ff @(posedge clk) begin
        if (en) begin
            ac7_reg <= PW'(ca) * PW'(cc);
            bs7_reg <= PW'(cb) * PW'(cs);
            as7_reg <= PW'(ca) * PW'(cs);
            bc7_reg <= PW'(cb) * PW'(cc);
            e7_reg  <= ce;
        end
    end

    logic v8_reg, e8_reg;
    logic signed [PW-1:0] re8_reg, im8_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) v8_reg <= 1'b0;
        else if (en) v8_reg <= v7_reg;
    end
    always_ff @(posedge clk) begin
        if (en) begin
            re8_reg <= ac7_reg - bs7_reg + (PW'(1) <<< 29);
            im8_reg <= as7_reg + bc7_reg + (PW'(1) <<< 29);
            e8_reg  <= e7_reg;
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [PW-1:0] v);
        logic signed [PW-31:0] r;
        logic signed [PW-31:0] hi;
        logic signed [PW-31:0] lo;
        r  = v[PW-1:30];
        hi = (PW-30)'((1 <<< (SAMPLE_BITS - 1)) - 1);
        lo = -hi - 1;
        if (r > hi) sat = hi[SAMPLE_BITS-1:0];
        else if (r < lo) sat = lo[SAMPLE_BITS-1:0];
        else sat = r[SAMPLE_BITS-1:0];
    endfunction

    logic out_valid_reg, evan_reg;
    logic signed [SAMPLE_BITS-1:0] re_reg, im_reg;
    assign en = !out_valid_reg || out_ready;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else if (en) out_valid_reg <= v8_reg;
    end
    always_ff @(posedge clk) begin
        if (en) begin
            re_reg   <= e8_reg ? '0 : sat(re8_reg);
            im_reg   <= e8_reg ? '0 : sat(im8_reg);
            evan_reg <= e8_reg;
        end
    end

    assign in_ready   = en;
    assign out_valid  = out_valid_reg;
    assign shifted_re = re_reg;
    assign shifted_im = im_reg;
    assign evanescent = evan_reg;

    `PSE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(shifted_re))
    `PSE_ASSERT_IMPL(a_evan_zero, out_valid && evanescent, shifted_re == 0 && shifted_im == 0)
    `PSE_ASSERT_IMPL(a_ready, out_valid && !out_ready, !in_ready)
endmodule
`default_nettype wire

### bench/tb.sv
`default_nettype none
module tb;
    import pse_pkg::*;

    localparam int LATENCY   = 3 + 17 + 4 + 16 + 3;
    localparam int MAX_CYCLES = 400000;

    // The atan table below is truncated Q.30 atan(2^-i).
    localparam logic [29:0] ATAN_TAB [0:15] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFD, 30'h07F56EA6,
        30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
        30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
        30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF
    };

    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               evan;
    } shifted_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic signed [15:0] wavenumber;
    logic [15:0] freq_over_velocity;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] shifted_re;
    logic signed [15:0] shifted_im;
    logic evanescent;
    logic depth_step_we;
    logic [15:0] depth_step_data;

    logic [15:0] dz;
    shifted_t expected_q[$];
    int errors;
    int cycles;
    bit idle_off;

    phase_shift_extrapolation DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .sample_re(sample_re), .sample_im(sample_im),
        .wavenumber(wavenumber), .freq_over_velocity(freq_over_velocity),
        .out_valid(out_valid), .out_ready(out_ready),
        .shifted_re(shifted_re), .shifted_im(shifted_im), .evanescent(evanescent),
        .depth_step_we(depth_step_we), .depth_step_data(depth_step_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint round_sat(input longint q45);
        longint r;
        r = floor_shr(q45 + (longint'(1) << 29), 30);
        if (r > 32767) return 32767;
        if (r < -32768) return -32768;
        return r;
    endfunction

    function automatic shifted_t phase_shift(input logic signed [15:0] a_in,
                                             input logic signed [15:0] b_in,
                                             input logic signed [15:0] k_in,
                                             input logic [15:0] fov_in);
        shifted_t r;
        longint a, b, k, x, y, z, dx, dy, c, s, absk, fov;
        longint unsigned diff, root, bitv, kz, ph;
        bit flip;
        a = a_in;
        b = b_in;
        k = k_in;
        fov = fov_in;
        absk = (k < 0) ? -k : k;
        r = '0;
        if (fov < absk)
        begin
            r.evan = 1'b1;
            return r;
        end
        diff = fov * fov - absk * absk;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > diff) bitv >>= 2;
        while (bitv != 0)
        begin
            if (diff >= root + bitv)
            begin
                diff -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        kz = root;
        ph = (kz * dz) << 10;
        z = longint'(ph % TWO_PI_Q30);
        if (z > longint'(PI_Q30)) z -= longint'(TWO_PI_Q30);
        flip = 1'b0;
        if (z > longint'(HALF_PI_Q30))
        begin
            z -= longint'(PI_Q30);
            flip = 1'b1;
        end
        else if (z < -longint'(HALF_PI_Q30))
        begin
            z += longint'(PI_Q30);
            flip = 1'b1;
        end
        x = INV_GAIN_Q30;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end
            else
            begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        r.re = 16'(round_sat(a * c - b * s));
        r.im = 16'(round_sat(a * s + b * c));
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        shifted_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result beat re=%0d im=%0d", shifted_re, shifted_im);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (shifted_re !== e.re)
                begin
                    $error("shifted_re expected %0d actual %0d", e.re, shifted_re);
                    errors++;
                end
                if (shifted_im !== e.im)
                begin
                    $error("shifted_im expected %0d actual %0d", e.im, shifted_im);
                    errors++;
                end
                if (evanescent !== e.evan)
                begin
                    $error("evanescent expected %0d actual %0d", e.evan, evanescent);
                    errors++;
                end
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (!idle_off && $urandom_range(0, 3) == 0)
            begin
                n = int'($urandom_range(1, 19));
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_sample(input logic [15:0] a, input logic [15:0] b,
                               input logic [15:0] k, input logic [15:0] fov);
        if (!idle_off && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_re <= a;
        sample_im <= b;
        wavenumber <= k;
        freq_over_velocity <= fov;
        expected_q.push_back(phase_shift(a, b, k, fov));
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic set_depth(input logic [15:0] v);
        drain();
        depth_step_we <= 1'b1;
        depth_step_data <= v;
        @(negedge clk);
        depth_step_we <= 1'b0;
        dz = v;
    endtask

    task automatic test_directed();
        send_sample(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);  // zero ratio, zero k
        send_sample(16'h8000, 16'h8000, 16'h0000, 16'h0000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h1000, 16'h2000);
        send_sample(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);  // most negative k
        send_sample(16'h1234, 16'h8765, 16'h8000, 16'h7FFF);  // evanescent
        send_sample(16'h4000, 16'hC000, 16'h7FFF, 16'h7FFF);  // ratio equals |k|
        send_sample(16'hFFFF, 16'h0001, 16'h7FFF, 16'h7FFE);
        send_sample(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
        send_sample(16'h0000, 16'h0000, 16'hFFFF, 16'h0001);
        send_sample(16'h5A5A, 16'hA5A5, 16'h0123, 16'h0C91);
    endtask

    task automatic test_depth_extremes();
        set_depth(16'h0000);
        send_sample(16'h7FFF, 16'h8000, 16'h0100, 16'h4000);
        send_sample(16'h8000, 16'h8000, 16'h0000, 16'hFFFF);
        set_depth(16'hFFFF);
        send_sample(16'h7FFF, 16'h8000, 16'h0100, 16'h4000);
        send_sample(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
        send_sample(16'h3333, 16'hCCCC, 16'h8000, 16'hFFFF);
    endtask

    task automatic test_random(input int count);
        logic [15:0] k, fov;
        for (int i = 0; i < count; i++)
        begin
            k = 16'($urandom);
            case ($urandom_range(0, 3))
                0: fov = 16'($urandom);
                1: fov = 16'($urandom_range(0, 255));
                default:
                begin
                    // mostly propagating beats
                    fov = 16'($urandom);
                    if (k[15]) k = -k;
                    if (fov < k) {fov, k} = {k, fov};
                    if ($urandom_range(0, 1)) k = -k;
                end
            endcase
            send_sample(16'($urandom), 16'($urandom), k, fov);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_re = '0;
        sample_im = '0;
        wavenumber = '0;
        freq_over_velocity = '0;
        depth_step_we = 1'b0;
        depth_step_data = '0;
        dz = 16'd256;
        errors = 0;
        cycles = 0;
        idle_off = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(300);
        test_depth_extremes();
        set_depth(16'($urandom));
        test_random(500);
        drain();  // sender waits for every result
        set_depth(16'h0001);
        test_random(300);
        set_depth(16'($urandom));
        test_random(500);
        idle_off = 1'b1;
        test_random(300);
        drain();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
